>>> hw/rtl/tct_pkg.sv
package tct_pkg;

  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 32;
  localparam int KEY_W    = 64;
  localparam int TIME_W   = 31;
  localparam int EXP_W    = 32;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_HIT     = 3'd0;
  localparam status_t ST_MISS    = 3'd1;
  localparam status_t ST_EXPIRED = 3'd2;
  localparam status_t ST_WRITTEN = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_ADD    = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic clear;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic clear_done;
  } sts_t;

endpackage

>>> hw/rtl/tct_ctrl.sv
module tct_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tct_pkg::sts_t sts,
  output tct_pkg::cmd_t cmd,
  output logic          busy
);
  import tct_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/tct_dp.sv
module tct_dp #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tct_pkg::cmd_t                 cmd,
  output tct_pkg::sts_t                 sts,
  input  logic                          mode,
  input  logic [tct_pkg::KEY_W-1:0]     name_key,
  input  logic [tct_pkg::ADDR_W-1:0]    new_address,
  input  logic [tct_pkg::TIME_W-1:0]    ttl_seconds,
  input  logic [tct_pkg::TIME_W-1:0]    now_seconds,
  output logic                          done,
  output tct_pkg::status_t              status,
  output logic [tct_pkg::ADDR_W-1:0]    found_address,
  output logic [tct_pkg::SLOT_W-1:0]    slot,
  output logic [tct_pkg::COUNT_W-1:0]   entry_count
);
  import tct_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  // table storage
  logic             valid_mem [ENTRIES];
  logic [KEY_W-1:0] key_mem   [ENTRIES];
  logic [ADDR_W-1:0] addr_mem [ENTRIES];
  logic [EXP_W-1:0] exp_mem   [ENTRIES];

  // latched transaction
  logic              q_mode;
  logic [KEY_W-1:0]  q_key;
  logic [ADDR_W-1:0] q_addr;
  logic [TIME_W-1:0] q_ttl;
  logic [TIME_W-1:0] q_now;

  // scan pipeline
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     eval_idx;
  logic              eval_valid;
  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;
  logic [ADDR_W-1:0] rd_address;
  logic [EXP_W-1:0]  rd_expiry;
  logic [AW-1:0]     clr_addr;

  // scan results
  logic              hit_found;
  logic              hit_is_exp;
  logic [AW-1:0]     hit_idx;
  logic [ADDR_W-1:0] hit_addr;
  logic              have_empty;
  logic [AW-1:0]     empty_idx;
  logic              have_early;
  logic [AW-1:0]     early_idx;
  logic [EXP_W-1:0]  early_exp;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;

  logic              key_eq;
  logic              rd_expired;
  logic              stop;
  logic              evaluating;

  logic              do_write;
  logic              do_del;
  logic              do_inc;
  logic [AW-1:0]     tgt;
  status_t           res_status;
  logic [ADDR_W-1:0] res_found;
  logic [EXP_W-1:0]  new_exp;

  assign evaluating = cmd.scan && eval_valid;
  assign key_eq     = rd_valid && (rd_key == q_key);
  assign rd_expired = (rd_expiry != '0) && ({1'b0, q_now} > rd_expiry);
  // add also stops at the first expired entry
  assign stop       = key_eq || ((q_mode == MODE_ADD) && rd_valid && rd_expired);

  assign sts.scan_done  = evaluating && (stop || (eval_idx == LAST));
  assign sts.clear_done = (clr_addr == LAST);

  assign new_exp = (q_ttl == '0) ? '0 : ({1'b0, q_now} + {1'b0, q_ttl});

  always_ff @(posedge clk) begin
    rd_valid   <= valid_mem[rd_addr];
    rd_key     <= key_mem[rd_addr];
    rd_address <= addr_mem[rd_addr];
    rd_expiry  <= exp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      valid_mem[clr_addr] <= 1'b0;
    end else if (cmd.commit && (do_write || do_del)) begin
      valid_mem[tgt] <= do_write;
    end
    if (cmd.commit && do_write) begin
      key_mem[tgt]  <= q_key;
      addr_mem[tgt] <= q_addr;
      exp_mem[tgt]  <= new_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_mode <= mode;
      q_key  <= name_key;
      q_addr <= new_address;
      q_ttl  <= ttl_seconds;
      q_now  <= now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr    <= '0;
      eval_valid <= 1'b0;
      eval_idx   <= '0;
      clr_addr   <= '0;
      hit_found  <= 1'b0;
      have_empty <= 1'b0;
      have_early <= 1'b0;
    end else begin
      if (cmd.clear && (clr_addr != LAST)) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.accept) begin
        rd_addr    <= '0;
        eval_valid <= 1'b0;
        hit_found  <= 1'b0;
        have_empty <= 1'b0;
        have_early <= 1'b0;
      end else if (cmd.scan) begin
        eval_valid <= 1'b1;
        eval_idx   <= rd_addr;
        if (rd_addr != LAST) begin
          rd_addr <= rd_addr + 1'b1;
        end
        if (evaluating) begin
          if (stop) begin
            hit_found <= 1'b1;
          end
          if (!rd_valid) begin
            if (!have_empty) begin
              have_empty <= 1'b1;
            end
          end else if (!key_eq && (rd_expiry != '0)) begin
            if (!have_early || (rd_expiry < early_exp)) begin
              have_early <= 1'b1;
            end
          end
        end
      end
    end
  end

  // payload side of the scan results
  always_ff @(posedge clk) begin
    if (evaluating) begin
      if (stop) begin
        hit_idx    <= eval_idx;
        hit_is_exp <= rd_expired;
        hit_addr   <= rd_address;
      end
      if (!rd_valid && !have_empty) begin
        empty_idx <= eval_idx;
      end
      if (rd_valid && !key_eq && (rd_expiry != '0)
          && (!have_early || (rd_expiry < early_exp))) begin
        early_idx <= eval_idx;
        early_exp <= rd_expiry;
      end
    end
  end

  always_comb begin
    do_write   = 1'b0;
    do_del     = 1'b0;
    do_inc     = 1'b0;
    tgt        = '0;
    res_status = ST_MISS;
    res_found  = '0;
    if (q_mode == MODE_ADD) begin
      res_status = ST_WRITTEN;
      do_write   = 1'b1;
      if (hit_found) begin
        tgt = hit_idx;
      end else if (have_empty) begin
        tgt    = empty_idx;
        do_inc = 1'b1;
      end else if (have_early) begin
        tgt = early_idx;
      end else begin
        do_write   = 1'b0;
        res_status = ST_FULL;
      end
    end else if (hit_found) begin
      tgt = hit_idx;
      if (hit_is_exp) begin
        do_del     = 1'b1;
        res_status = ST_EXPIRED;
      end else begin
        res_status = ST_HIT;
        res_found  = hit_addr;
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_inc) begin
      count_next = count + 1'b1;
    end else if (do_del && (count != '0)) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status        <= res_status;
      found_address <= res_found;
      slot          <= SLOT_W'(tgt);
      entry_count   <= COUNT_W'(count_next);
    end
  end

endmodule

>>> hw/rtl/ttl_cache_table.sv
// channel  | signals                                            | transaction when
// ---------+----------------------------------------------------+---------------------
// request  | start, busy, mode, name_key, new_address,          | start && !busy
//          | ttl_seconds, now_seconds                           |
// result   | done, status, found_address, slot, entry_count     | done (one cycle)
//
// A transaction scans the table one slot per cycle through the read port of the slot
// memories, stopping at the deciding slot, then writes back in the commit state.
// busy stays high through the scan and the write-back; done follows.
// A new request is taken in the cycle that done is shown.
// After reset, a clearing pass over every slot empties the valid store, busy high.
// Results cannot be stalled: done lasts exactly one cycle.
module ttl_cache_table #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [tct_pkg::KEY_W-1:0]     name_key,
  input  logic [tct_pkg::ADDR_W-1:0]    new_address,
  input  logic [tct_pkg::TIME_W-1:0]    ttl_seconds,
  input  logic [tct_pkg::TIME_W-1:0]    now_seconds,
  output logic                          done,
  output tct_pkg::status_t              status,
  output logic [tct_pkg::ADDR_W-1:0]    found_address,
  output logic [tct_pkg::SLOT_W-1:0]    slot,
  output logic [tct_pkg::COUNT_W-1:0]   entry_count
);
  import tct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .name_key      (name_key),
    .new_address   (new_address),
    .ttl_seconds   (ttl_seconds),
    .now_seconds   (now_seconds),
    .done          (done),
    .status        (status),
    .found_address (found_address),
    .slot          (slot),
    .entry_count   (entry_count)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_HIT)) |-> (found_address == '0))
    else $error("address returned without a hit");

  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == ST_MISS) || (status == ST_FULL))) |-> (slot == '0))
    else $error("slot reported on miss or full table");

endmodule

>>> dv/ttl_cache_table_tb.sv
module ttl_cache_table_tb;
  import tct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES        = 64;
  localparam int KEY_POOL       = 120;
  localparam int WATCHDOG_LIMIT = 20 * (ENTRIES + 2);
  localparam int MAX_REPORTS    = 30;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] ttl;
    logic [TIME_W-1:0] now;
  } cache_req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  found;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } cache_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic mode = MODE_LOOKUP;
  logic [KEY_W-1:0] name_key = '0;
  logic [ADDR_W-1:0] new_address = '0;
  logic [TIME_W-1:0] ttl_seconds = '0;
  logic [TIME_W-1:0] now_seconds = '0;
  logic busy;
  logic done;
  status_t status;
  logic [ADDR_W-1:0] found_address;
  logic [SLOT_W-1:0] slot;
  logic [COUNT_W-1:0] entry_count;

  // shadow copy of the table
  logic              shadow_valid [ENTRIES] = '{default: 1'b0};
  logic [KEY_W-1:0]  shadow_key [ENTRIES];
  logic [ADDR_W-1:0] shadow_addr [ENTRIES];
  logic [EXP_W-1:0]  shadow_expiry [ENTRIES];
  int                shadow_count = 0;

  cache_req_t pending_reqs[$];
  cache_rsp_t expected_results[$];
  cache_req_t on_bus;
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  int sender_gap_pct = 31;
  int queued_count = 0;
  int accepted_count = 0;
  int result_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int status_tally [5] = '{default: 0};
  int sim_clock_s = 0;

  ttl_cache_table #(.ENTRIES(ENTRIES)) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .name_key     (name_key),
    .new_address  (new_address),
    .ttl_seconds  (ttl_seconds),
    .now_seconds  (now_seconds),
    .done         (done),
    .status       (status),
    .found_address(found_address),
    .slot         (slot),
    .entry_count  (entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_stale(input logic [EXP_W-1:0] expiry,
                                  input logic [TIME_W-1:0] now);
    return expiry != '0 && {1'b0, now} > expiry;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at result %0d (%0t): %s got %0h expected %0h",
               result_count, $time, what, got, want);
  endtask

  task automatic predict_lookup_or_add(input cache_req_t r);
    cache_rsp_t rsp;
    bit have_match, have_stale, have_empty, have_early, do_write;
    int match_i, stale_i, empty_i, early_i, target;
    logic [EXP_W-1:0] e;
    rsp.status = ST_MISS;
    rsp.found = '0;
    rsp.slot = '0;
    have_match = 0;
    have_stale = 0;
    have_empty = 0;
    have_early = 0;
    match_i = 0;
    stale_i = 0;
    empty_i = 0;
    early_i = 0;
    target = 0;
    if (r.mode == MODE_ADD) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!shadow_valid[i]) begin
          if (!have_empty) begin
            have_empty = 1;
            empty_i = i;
          end
        end else if (shadow_key[i] == r.key) begin
          have_match = 1;
          match_i = i;
          break;
        end else begin
          e = shadow_expiry[i];
          // earliest positive expiry seen so far, ties to the lowest slot
          if (e != '0 && (!have_early || e < shadow_expiry[early_i])) begin
            have_early = 1;
            early_i = i;
          end
          if (is_stale(e, r.now)) begin
            have_stale = 1;
            stale_i = i;
            break;
          end
        end
      end
      do_write = 1;
      if (have_match) target = match_i;
      else if (have_stale) target = stale_i;
      else if (have_empty) begin
        target = empty_i;
        shadow_count++;
      end else if (have_early) target = early_i;
      else do_write = 0;
      if (do_write) begin
        shadow_valid[target] = 1'b1;
        shadow_key[target] = r.key;
        shadow_addr[target] = r.addr;
        shadow_expiry[target] = (r.ttl == '0) ? '0 : {1'b0, r.now} + {1'b0, r.ttl};
        rsp.status = ST_WRITTEN;
        rsp.slot = SLOT_W'(target);
      end else begin
        rsp.status = ST_FULL;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_valid[i] && shadow_key[i] == r.key) begin
          rsp.slot = SLOT_W'(i);
          if (is_stale(shadow_expiry[i], r.now)) begin
            shadow_valid[i] = 1'b0;
            if (shadow_count > 0) shadow_count--;
            rsp.status = ST_EXPIRED;
          end else begin
            rsp.status = ST_HIT;
            rsp.found = shadow_addr[i];
          end
          break;
        end
      end
    end
    rsp.count = COUNT_W'(shadow_count);
    status_tally[rsp.status]++;
    expected_results.push_back(rsp);
  endtask

  // driver: one transaction per start && !busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_lookup_or_add(on_bus);
        accepted_count++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          on_bus = pending_reqs.pop_front();
          mode <= on_bus.mode;
          name_key <= on_bus.key;
          new_address <= on_bus.addr;
          ttl_seconds <= on_bus.ttl;
          now_seconds <= on_bus.now;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cache_rsp_t want_rsp;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding", 64'(status), 64'(0));
      end else begin
        want_rsp = expected_results.pop_front();
        if (status !== want_rsp.status)
          report_mismatch("status", 64'(status), 64'(want_rsp.status));
        if (found_address !== want_rsp.found)
          report_mismatch("found_address", 64'(found_address), 64'(want_rsp.found));
        if (slot !== want_rsp.slot)
          report_mismatch("slot", 64'(slot), 64'(want_rsp.slot));
        if (entry_count !== want_rsp.count)
          report_mismatch("entry_count", 64'(entry_count), 64'(want_rsp.count));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic queue_request(input logic m, input logic [KEY_W-1:0] k,
                               input logic [ADDR_W-1:0] a, input logic [TIME_W-1:0] ttl,
                               input logic [TIME_W-1:0] now);
    cache_req_t r;
    r.mode = m;
    r.key = k;
    r.addr = a;
    r.ttl = ttl;
    r.now = now;
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  task automatic wait_queue_empty();
    while (pending_reqs.size() != 0) @(negedge clk);
  endtask

  task automatic gen_directed();
    logic [KEY_W-1:0] key_c, key_d, key_e, key_f;
    key_c = {$urandom, $urandom};
    key_d = {$urandom, $urandom};
    key_e = {$urandom, $urandom};
    key_f = {$urandom, $urandom};
    queue_request(MODE_LOOKUP, '0, '0, '0, '0);                 // miss on empty table
    queue_request(MODE_ADD, '0, '1, 31'd10, '0);
    queue_request(MODE_ADD, '1, '0, '0, '0);                    // permanent
    queue_request(MODE_ADD, key_c, 32'h0a000001, 31'd5, '0);
    queue_request(MODE_LOOKUP, '0, '0, '0, 31'd10);             // at expiry: still live
    queue_request(MODE_ADD, '0, 32'h5555aaaa, 31'd20, 31'd10);  // refresh
    queue_request(MODE_LOOKUP, key_c, '0, '0, 31'd6);           // expired, deleted
    queue_request(MODE_LOOKUP, key_c, '0, '0, 31'd6);
    queue_request(MODE_ADD, key_d, 32'hc0a80101, 31'd3, 31'd6); // reuses the freed slot
    queue_request(MODE_ADD, key_e, 32'h7f000001, 31'd100, 31'd6);
    // stale slot ahead of a later copy of the same key
    queue_request(MODE_ADD, key_e, 32'h01020304, 31'd7, 31'd50);
    queue_request(MODE_LOOKUP, key_e, '0, '0, 31'd50);
    queue_request(MODE_LOOKUP, '1, '0, '0, TIME_MAX);
    queue_request(MODE_ADD, key_f, 32'hffff0000, TIME_MAX, TIME_MAX); // largest expiry
    queue_request(MODE_LOOKUP, key_f, '0, '0, TIME_MAX);
    queue_request(MODE_LOOKUP, key_d, '1, '1, 31'd9);
    queue_request(MODE_LOOKUP, key_d, '1, '1, 31'd10);
  endtask

  // all slots pinned with permanent entries, then unpinned with short lifetimes
  task automatic gen_table_fill();
    logic [KEY_W-1:0] pinned [ENTRIES+4];
    for (int i = 0; i < ENTRIES + 4; i++) begin
      pinned[i] = {$urandom, $urandom};
      queue_request(MODE_ADD, pinned[i], $urandom, '0, TIME_W'(sim_clock_s));
      sim_clock_s += $urandom_range(3);
    end
    for (int i = 0; i < 8; i++)
      queue_request(MODE_LOOKUP, pinned[$urandom_range(ENTRIES + 3)], $urandom,
                    TIME_W'($urandom), TIME_W'(sim_clock_s));
    for (int i = 0; i < ENTRIES + 4; i++) begin
      queue_request(MODE_ADD, pinned[i], $urandom, TIME_W'($urandom_range(30, 1)),
                    TIME_W'(sim_clock_s));
      sim_clock_s += $urandom_range(2);
    end
  endtask

  task automatic gen_mixed_traffic(input int n);
    int left, run, pool_n, ttl_span, add_pct, pick;
    logic [KEY_W-1:0] k;
    logic [ADDR_W-1:0] a;
    logic [TIME_W-1:0] ttl;
    left = n;
    while (left > 0) begin
      run = $urandom_range(60, 20);
      if (run > left) run = left;
      pool_n = $urandom_range(1) ? $urandom_range(12, 4) : $urandom_range(KEY_POOL, 70);
      ttl_span = $urandom_range(1) ? $urandom_range(40, 2) : $urandom_range(4000, 200);
      add_pct = $urandom_range(80, 30);
      for (int j = 0; j < run; j++) begin
        sim_clock_s += $urandom_range(6);
        if ($urandom_range(99) < 8) begin
          // noise: any field value at all
          queue_request(1'($urandom_range(1)), {$urandom, $urandom}, $urandom,
                        TIME_W'($urandom), TIME_W'($urandom));
        end else begin
          k = key_pool[$urandom_range(pool_n - 1)];
          pick = $urandom_range(99);
          if (pick < 5) ttl = '0;
          else if (pick < 7) ttl = TIME_MAX;
          else ttl = TIME_W'($urandom_range(ttl_span, 1));
          pick = $urandom_range(99);
          if (pick < 5) a = '0;
          else if (pick < 10) a = '1;
          else a = $urandom;
          if ($urandom_range(99) < add_pct)
            queue_request(MODE_ADD, k, a, ttl, TIME_W'(sim_clock_s));
          else
            queue_request(MODE_LOOKUP, k, a, ttl, TIME_W'(sim_clock_s));
        end
      end
      left -= run;
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gen_directed();
    sim_clock_s = $urandom_range(1000);
    gen_mixed_traffic(250);
    wait_queue_empty();

    sender_gap_pct = 63;
    gen_table_fill();
    gen_mixed_traffic(150);
    wait_queue_empty();

    sender_gap_pct = 0;
    gen_mixed_traffic(270);

    while (accepted_count != queued_count) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (ENTRIES + 4) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results still outstanding", 64'(expected_results.size()), 64'(0));

    $display("%0d transactions checked: %0d hits, %0d misses, %0d expired, %0d written,",
             result_count, status_tally[ST_HIT], status_tally[ST_MISS],
             status_tally[ST_EXPIRED], status_tally[ST_WRITTEN]);
    $display("%0d rejected with table pinned, %0d mismatches",
             status_tally[ST_FULL], mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tct_pkg.sv
hw/rtl/tct_ctrl.sv
hw/rtl/tct_dp.sv
hw/rtl/ttl_cache_table.sv
dv/ttl_cache_table_tb.sv
